>>> rtl/iss_pkg.sv
// Shared types and constants for the indexed sequence store.
// Holds sizes, operation and status codes, and the cell command struct.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package iss_pkg;

	localparam int DEPTH      = 16;
	localparam int DATA_WIDTH = 32;

	// Widths fixed by the external interface.
	localparam int OP_W    = 2;
	localparam int POS_W   = 7;
	localparam int ENTRY_W = 32;
	localparam int STAT_W  = 2;

	// Widths that follow from the depth.
	localparam int IDX_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);
	localparam int IDXS_W  = CNT_W + 1;
	localparam int SUM_W   = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

	typedef enum logic [OP_W-1:0] {
		OP_INSERT = 2'd0,
		OP_READ   = 2'd1,
		OP_TAKE   = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	typedef enum logic [STAT_W-1:0] {
		ST_OK        = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_UNUSED    = 2'd3
	} status_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic                  apply;
		logic                  is_insert;
		logic [CNT_W-1:0]      index;
		logic [CNT_W-1:0]      length;
		logic [DATA_WIDTH-1:0] word;
	} cmd_t;

endpackage

`default_nettype wire

>>> rtl/iss_cell.sv
// One storage cell of the sequence chain.
// Holds one word; loads the new word, its left neighbor or its right neighbor.
// Depends on iss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module iss_cell (
	input  wire                             clk,
	input  wire  [iss_pkg::IDX_W-1:0]       cell_index,
	input  iss_pkg::cmd_t                   cmd,
	input  wire  [iss_pkg::DATA_WIDTH-1:0]  left_word,
	input  wire  [iss_pkg::DATA_WIDTH-1:0]  right_word,
	output logic [iss_pkg::DATA_WIDTH-1:0]  word
);

	logic [iss_pkg::CNT_W-1:0] pos;
	logic [iss_pkg::CNT_W:0]   pos_next;
	logic [iss_pkg::DATA_WIDTH-1:0] word_q;

	assign pos      = iss_pkg::CNT_W'(cell_index);
	assign pos_next = {1'b0, pos} + (iss_pkg::CNT_W + 1)'(1);
	assign word     = word_q;

	// An insert opens a gap at the index; a take closes the gap left at the index.
	always_ff @(posedge clk) begin
		if (cmd.apply) begin
			if (cmd.is_insert) begin
				if (pos == cmd.index) begin
					word_q <= cmd.word;
				end else if (pos > cmd.index && pos <= cmd.length) begin
					word_q <= left_word;
				end
			end else begin
				if (pos >= cmd.index && pos_next < {1'b0, cmd.length}) begin
					word_q <= right_word;
				end
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/indexed_sequence_store.sv
// Indexed sequence store: a chain of word cells that shift together on insert and take.
// A request is captured at acceptance and its result is registered in the output register
// once that register can take it, so a stall on the output holds the request; one request
// is in work at a time, so a new request is not taken until the last one has executed.
// Reset clears the length, busy flag and output valid; cell contents stay undefined.
// Depends on iss_pkg and iss_cell.
`timescale 1ns / 1ps
`default_nettype none

module indexed_sequence_store (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             in_valid,
	output logic                            in_ready,
	input  wire  [iss_pkg::OP_W-1:0]        op,
	input  wire  signed [iss_pkg::POS_W-1:0] position,
	input  wire                             at_end,
	input  wire  [iss_pkg::ENTRY_W-1:0]     entry_value,
	output logic                            out_valid,
	input  wire                             out_ready,
	output logic [iss_pkg::CNT_W-1:0]       position_used,
	output logic [iss_pkg::ENTRY_W-1:0]     entry_out,
	output logic [iss_pkg::STAT_W-1:0]      status,
	output logic [iss_pkg::CNT_W-1:0]       count
);

	// Control state.
	logic                        busy_q;
	logic                        out_valid_q;
	logic [iss_pkg::CNT_W-1:0]   length_q;

	// Request captured at acceptance, with its position already normalized.
	iss_pkg::op_t                      op_s1;
	logic signed [iss_pkg::IDXS_W-1:0] idx_s1;
	logic [iss_pkg::DATA_WIDTH-1:0]    word_s1;

	// Output register.
	logic [iss_pkg::CNT_W-1:0]   position_used_q;
	logic [iss_pkg::ENTRY_W-1:0] entry_out_q;
	iss_pkg::status_t            status_q;
	logic [iss_pkg::CNT_W-1:0]   count_q;

	// Normalization of the incoming position against the current length.
	logic signed [iss_pkg::SUM_W-1:0]  pos_sx;
	logic signed [iss_pkg::SUM_W-1:0]  len_sx;
	logic signed [iss_pkg::SUM_W-1:0]  sum_sx;
	logic signed [iss_pkg::IDXS_W-1:0] idx_norm;

	// Execute step.
	logic                            accept;
	logic                            exec;
	logic                            idx_neg;
	logic [iss_pkg::CNT_W-1:0]       idx_u;
	logic                            found;
	logic                            full;
	logic [iss_pkg::CNT_W-1:0]       ins_idx;
	logic [iss_pkg::DATA_WIDTH-1:0]  read_word;
	iss_pkg::cmd_t                   cmd;
	logic [iss_pkg::DATA_WIDTH-1:0]  cell_word [iss_pkg::DEPTH];

	assign in_ready      = !busy_q;
	assign accept        = in_valid && in_ready;
	// The execute step runs once the output register can take its result.
	assign exec          = busy_q && (!out_valid_q || out_ready);

	assign out_valid     = out_valid_q;
	assign position_used = position_used_q;
	assign entry_out     = entry_out_q;
	assign status        = status_q;
	assign count         = count_q;

	// A negative position counts back from the length; if it reaches before the
	// head it becomes minus one. A positive position beyond the length clamps to it.
	always_comb begin
		pos_sx = iss_pkg::SUM_W'(position);
		len_sx = signed'(iss_pkg::SUM_W'(length_q));
		sum_sx = len_sx + pos_sx;
		if (at_end) begin
			idx_norm = signed'(iss_pkg::IDXS_W'(length_q));
		end else if (position < 0) begin
			if (sum_sx < 0) begin
				idx_norm = -iss_pkg::IDXS_W'(1);
			end else begin
				idx_norm = iss_pkg::IDXS_W'(sum_sx);
			end
		end else if (pos_sx > len_sx) begin
			idx_norm = signed'(iss_pkg::IDXS_W'(length_q));
		end else begin
			idx_norm = iss_pkg::IDXS_W'(pos_sx);
		end
	end

	// Decode of the captured request. The chain is only told to move when the
	// request really changes the sequence: an insert into a store with room, or
	// a take of an entry that exists.
	always_comb begin
		idx_neg   = idx_s1[iss_pkg::IDXS_W-1];
		idx_u     = idx_s1[iss_pkg::CNT_W-1:0];
		found     = !idx_neg && (idx_u < length_q);
		full      = (length_q == iss_pkg::CNT_W'(iss_pkg::DEPTH));
		ins_idx   = idx_neg ? '0 : idx_u;
		read_word = cell_word[idx_u[iss_pkg::IDX_W-1:0]];

		cmd.is_insert = (op_s1 == iss_pkg::OP_INSERT);
		cmd.index     = cmd.is_insert ? ins_idx : idx_u;
		cmd.length    = length_q;
		cmd.word      = word_s1;
		cmd.apply     = exec && ((cmd.is_insert && !full) ||
		                         (op_s1 == iss_pkg::OP_TAKE && found));
	end

	// The chain of cells: each one sees both neighbors, the ends see zero.
	for (genvar i = 0; i < iss_pkg::DEPTH; i++) begin : g_cell
		logic [iss_pkg::DATA_WIDTH-1:0] left_word;
		logic [iss_pkg::DATA_WIDTH-1:0] right_word;

		if (i == 0) begin : g_head
			assign left_word = '0;
		end else begin : g_body
			assign left_word = cell_word[i-1];
		end

		if (i == iss_pkg::DEPTH - 1) begin : g_tail
			assign right_word = '0;
		end else begin : g_inner
			assign right_word = cell_word[i+1];
		end

		iss_cell u_cell (
			.clk        (clk),
			.cell_index (iss_pkg::IDX_W'(i)),
			.cmd        (cmd),
			.left_word  (left_word),
			.right_word (right_word),
			.word       (cell_word[i])
		);
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			out_valid_q <= 1'b0;
			length_q    <= '0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (exec) begin
				busy_q <= 1'b0;
			end

			if (exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end

			if (cmd.apply) begin
				if (cmd.is_insert) begin
					length_q <= length_q + iss_pkg::CNT_W'(1);
				end else begin
					length_q <= length_q - iss_pkg::CNT_W'(1);
				end
			end
		end
	end

	// Request capture.
	always_ff @(posedge clk) begin
		if (accept) begin
			op_s1   <= iss_pkg::op_t'(op);
			idx_s1  <= idx_norm;
			word_s1 <= iss_pkg::DATA_WIDTH'(entry_value);
		end
	end

	// Result register. The count shown is the length after this request.
	always_ff @(posedge clk) begin
		if (exec) begin
			position_used_q <= '0;
			entry_out_q     <= '0;
			status_q        <= iss_pkg::ST_OK;
			count_q         <= length_q;
			unique case (op_s1)
				iss_pkg::OP_INSERT: begin
					if (full) begin
						status_q <= iss_pkg::ST_FULL;
					end else begin
						position_used_q <= ins_idx;
						count_q         <= length_q + iss_pkg::CNT_W'(1);
					end
				end
				iss_pkg::OP_READ, iss_pkg::OP_TAKE: begin
					if (found) begin
						entry_out_q <= iss_pkg::ENTRY_W'(read_word);
						if (op_s1 == iss_pkg::OP_TAKE) begin
							count_q <= length_q - iss_pkg::CNT_W'(1);
						end
					end else begin
						status_q <= iss_pkg::ST_NOT_FOUND;
					end
				end
				default: begin
					status_q <= iss_pkg::ST_NOT_FOUND;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

>>> rtl/iss_checker.sv
// Port-level checker for the indexed sequence store, bound to the top level.
// Depends on iss_pkg and indexed_sequence_store.
`timescale 1ns / 1ps
`default_nettype none

module iss_checker (
	input wire                            clk,
	input wire                            arst_n,
	input wire                            in_valid,
	input wire                            in_ready,
	input wire                            out_valid,
	input wire                            out_ready,
	input wire [iss_pkg::CNT_W-1:0]       position_used,
	input wire [iss_pkg::ENTRY_W-1:0]     entry_out,
	input wire [iss_pkg::STAT_W-1:0]      status,
	input wire [iss_pkg::CNT_W-1:0]       count
);

	// Only one request is in work at a time.
	a_one_in_work: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("request accepted while another was in work");

	// A new result only appears after a request was being worked on.
	a_result_follows_request: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready))
		else $error("result appeared without a request in work");

	// A full report means the store really holds DEPTH entries, with position and entry zero.
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status == iss_pkg::ST_FULL |->
			count == iss_pkg::CNT_W'(iss_pkg::DEPTH) && position_used == '0 &&
			entry_out == '0)
		else $error("full status with wrong count or payload");

	// A valid count never exceeds the depth.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> count <= iss_pkg::CNT_W'(iss_pkg::DEPTH))
		else $error("count beyond depth");

	// A stalled result holds.
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(count) && $stable(status) &&
			$stable(entry_out) && $stable(position_used))
		else $error("stalled result changed");

endmodule

bind indexed_sequence_store iss_checker u_iss_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.in_valid      (in_valid),
	.in_ready      (in_ready),
	.out_valid     (out_valid),
	.out_ready     (out_ready),
	.position_used (position_used),
	.entry_out     (entry_out),
	.status        (status),
	.count         (count)
);

`default_nettype wire
